/* sv/rectify_map_nearest_search_top_macros.svh */
// Assertion macros for the rectify map nearest search block.
// Included by the top level; no other dependencies.
`ifndef RECTIFY_MAP_NEAREST_SEARCH_TOP_MACROS_SVH
`define RECTIFY_MAP_NEAREST_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define RMNS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("rmns assertion failed");
// Check that cons holds in the cycle after ante.
`define RMNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rmns assertion failed");
`else
`define RMNS_ASSERT(lbl, clk, rstn, prop)
`define RMNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/rmns_pkg.sv */
// Shared constants and types for the rectify map nearest search block.
// No dependencies.
package rmns_pkg;

	localparam int IMG_WIDTH_DEF  = 320;
	localparam int IMG_HEIGHT_DEF = 240;

	localparam int CMD_W    = 2;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 9;
	localparam int COORD_W  = 11;
	localparam int DIST_W   = 24;
	localparam int RADIUS_W = 6;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd30;
	localparam logic [DIST_W-1:0]   DIST_MAX     = 24'hFFFFFF;

	localparam logic [CMD_W-1:0] CMD_LOAD_REF = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_QRY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QRD,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} rmns_state_t;

endpackage

/* sv/rmns_dist.sv */
// Two-stage squared distance unit: squares, then saturating sum.
// Depends on rmns_pkg.
module rmns_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [rmns_pkg::COORD_W-1:0] ref_x,
	input  logic signed [rmns_pkg::COORD_W-1:0] ref_y,
	input  logic signed [rmns_pkg::COORD_W-1:0] q_x,
	input  logic signed [rmns_pkg::COORD_W-1:0] q_y,
	output logic                                out_valid,
	output logic        [rmns_pkg::DIST_W-1:0]  sq_dist
);
	import rmns_pkg::*;

	localparam int SQ_W = 2 * (COORD_W + 1);

	logic signed [COORD_W:0] dx, dy;
	logic [SQ_W-1:0]         sq_x, sq_y;
	logic [SQ_W-1:0]         sq_x_s2, sq_y_s2;
	logic                    v_s2;
	logic [SQ_W:0]           sum;
	logic [DIST_W-1:0]       dist_s3;
	logic                    v_s3;

	always_comb begin
		dx   = (COORD_W+1)'(ref_x) - (COORD_W+1)'(q_x);
		dy   = (COORD_W+1)'(ref_y) - (COORD_W+1)'(q_y);
		sq_x = SQ_W'(dx * dx);
		sq_y = SQ_W'(dy * dy);
		sum  = (SQ_W+1)'(sq_x_s2) + (SQ_W+1)'(sq_y_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2 <= sq_x;
		sq_y_s2 <= sq_y;
		// saturate at the top of the result range
		dist_s3 <= (sum > (SQ_W+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
	end

	assign out_valid = v_s3;
	assign sq_dist   = dist_s3;

endmodule

/* sv/rectify_map_nearest_search_top.sv */
// Top level of the rectify map nearest search block: map memories, sequencer, best tracker.
// Depends on rmns_pkg, rmns_dist and rectify_map_nearest_search_top_macros.svh.
//
// Items arrive on start/cmd/row/col/map_x/map_y and are taken when start is high and busy
// is low. A load (cmd 0 reference, cmd 1 query) writes one map entry; busy stays low, so
// loads can be issued every cycle. A query (cmd 2) raises busy and produces exactly one
// result: done pulses high for one cycle while found, match_col, match_row and
// best_distance are valid. The receiver cannot stall, so sample on done. A query reads
// its target point (state QRD), sets up the window (SETUP), scans the window positions
// (SCAN), drains the distance pipeline (DRAIN) and shows the result (DONE). The window
// scan is set by the single read port of the reference map memory, one entry per cycle.
// A query outside the image or with an empty window returns found = 0 with all fields 0.
// Loads outside the image and cmd 3 are accepted and dropped. The maps need no clearing
// after reset; reading an entry that was never loaded gives an undefined position. Write
// window_radius only while busy is low.
`include "rectify_map_nearest_search_top_macros.svh"

module rectify_map_nearest_search_top #(
	parameter int IMG_WIDTH  = rmns_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = rmns_pkg::IMG_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 window_radius_we,
	input  logic        [rmns_pkg::RADIUS_W-1:0] window_radius,
	input  logic                                 start,
	output logic                                 busy,
	input  logic        [rmns_pkg::CMD_W-1:0]    cmd,
	input  logic        [rmns_pkg::ROW_W-1:0]    row,
	input  logic        [rmns_pkg::COL_W-1:0]    col,
	input  logic signed [rmns_pkg::COORD_W-1:0]  map_x,
	input  logic signed [rmns_pkg::COORD_W-1:0]  map_y,
	output logic                                 done,
	output logic                                 found,
	output logic        [rmns_pkg::COL_W-1:0]    match_col,
	output logic        [rmns_pkg::ROW_W-1:0]    match_row,
	output logic        [rmns_pkg::DIST_W-1:0]   best_distance
);
	import rmns_pkg::*;

	localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(IMG_HEIGHT);
	localparam int CW    = $clog2(IMG_WIDTH);
	localparam int MW    = 2 * COORD_W;
	localparam int BW    = 13;   // signed bound arithmetic, holds +-4095
	localparam int LW    = 11;   // holds the image limits up to 1024

	localparam logic [AW-1:0]        W_A = AW'(IMG_WIDTH);
	localparam logic [LW-1:0]        W_L = LW'(IMG_WIDTH);
	localparam logic [LW-1:0]        H_L = LW'(IMG_HEIGHT);
	localparam logic signed [BW-1:0] W_S = BW'(IMG_WIDTH);
	localparam logic signed [BW-1:0] H_S = BW'(IMG_HEIGHT);

	// configuration
	logic [RADIUS_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (window_radius_we) begin
			radius_q <= window_radius;
		end
	end

	// input decode
	logic          in_range;
	logic [AW-1:0] in_addr;

	assign in_range = (LW'(row) < H_L) && (LW'(col) < W_L);
	assign in_addr  = AW'(row) * W_A + AW'(col);

	// sequencer
	rmns_state_t state_q, state_d;
	logic ref_we, qry_we, qry_rd, clear_best, load_bounds, setup, issue;
	logic empty_q, last_col, last_row, pipe_busy;
	logic v_s1, v_s2, dist_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ref_we      = 1'b0;
		qry_we      = 1'b0;
		qry_rd      = 1'b0;
		clear_best  = 1'b0;
		load_bounds = 1'b0;
		setup       = 1'b0;
		issue       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_LOAD_REF: ref_we = in_range;
						CMD_LOAD_QRY: qry_we = in_range;
						CMD_QUERY: begin
							clear_best = 1'b1;
							if (in_range) begin
								qry_rd  = 1'b1;
								state_d = ST_QRD;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_QRD: begin
				load_bounds = 1'b1;
				state_d     = ST_SETUP;
			end
			ST_SETUP: begin
				setup   = 1'b1;
				state_d = empty_q ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_col && last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// query map memory: {y, x} per pixel
	logic [MW-1:0] qry_mem [DEPTH];
	logic [MW-1:0] qry_rd_q;

	always_ff @(posedge clk) begin
		if (qry_we) begin
			qry_mem[in_addr] <= {map_y, map_x};
		end
		if (qry_rd) begin
			qry_rd_q <= qry_mem[in_addr];
		end
	end

	// window bounds, clamped to the image, upper bound exclusive
	logic signed [BW-1:0] qx_b, qy_b, r_b;
	logic signed [BW-1:0] lo_x, lo_y, hi_x, hi_y, x0_b, y0_b, x1_b, y1_b;
	logic signed [BW-1:0] x_last_b, y_last_b;

	always_comb begin
		qx_b     = BW'(signed'(qry_rd_q[COORD_W-1:0]));
		qy_b     = BW'(signed'(qry_rd_q[MW-1:COORD_W]));
		r_b      = BW'(radius_q);
		lo_x     = qx_b - r_b;
		lo_y     = qy_b - r_b;
		hi_x     = qx_b + r_b;
		hi_y     = qy_b + r_b;
		x0_b     = (lo_x < 0) ? '0 : lo_x;
		y0_b     = (lo_y < 0) ? '0 : lo_y;
		x1_b     = (hi_x > W_S) ? W_S : hi_x;
		y1_b     = (hi_y > H_S) ? H_S : hi_y;
		x_last_b = x1_b - BW'(1);
		y_last_b = y1_b - BW'(1);
	end

	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic [CW-1:0] x0_q, x_last_q, j_q;
	logic [RW-1:0] y0_q, y_last_q, i_q;
	logic [AW-1:0] base_q, scan_addr;

	always_ff @(posedge clk) begin
		if (load_bounds) begin
			qx_q     <= qry_rd_q[COORD_W-1:0];
			qy_q     <= qry_rd_q[MW-1:COORD_W];
			// the truncated bounds matter only for a non-empty window
			x0_q     <= x0_b[CW-1:0];
			y0_q     <= y0_b[RW-1:0];
			x_last_q <= x_last_b[CW-1:0];
			y_last_q <= y_last_b[RW-1:0];
			empty_q  <= (x0_b >= x1_b) || (y0_b >= y1_b);
		end
	end

	// raster scan counters with a running row base address
	assign last_col  = (j_q == x_last_q);
	assign last_row  = (i_q == y_last_q);
	assign scan_addr = base_q + AW'(j_q);

	always_ff @(posedge clk) begin
		if (setup) begin
			i_q    <= y0_q;
			j_q    <= x0_q;
			base_q <= AW'(y0_q) * W_A;
		end else if (issue) begin
			if (last_col) begin
				j_q    <= x0_q;
				i_q    <= i_q + RW'(1);
				base_q <= base_q + W_A;
			end else begin
				j_q <= j_q + CW'(1);
			end
		end
	end

	// reference map memory, read once per window position
	logic [MW-1:0] ref_mem [DEPTH];
	logic [MW-1:0] ref_rd_s1;

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[in_addr] <= {map_y, map_x};
		end
		if (issue) begin
			ref_rd_s1 <= ref_mem[scan_addr];
		end
	end

	// carry the window position alongside the distance pipeline
	logic [CW-1:0] col_s1, col_s2, col_s3;
	logic [RW-1:0] row_s1, row_s2, row_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= j_q;
		row_s1 <= i_q;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		col_s3 <= col_s2;
		row_s3 <= row_s2;
	end

	logic [DIST_W-1:0] dist_s3;

	rmns_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.ref_x     (ref_rd_s1[COORD_W-1:0]),
		.ref_y     (ref_rd_s1[MW-1:COORD_W]),
		.q_x       (qx_q),
		.q_y       (qy_q),
		.out_valid (dist_valid),
		.sq_dist   (dist_s3)
	);

	assign pipe_busy = v_s1 || v_s2 || dist_valid;

	// best tracker: strict less-than keeps the first position in raster order on ties
	logic              have_q;
	logic [DIST_W-1:0] best_q;
	logic [CW-1:0]     best_col_q;
	logic [RW-1:0]     best_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
		end else if (clear_best) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_col_q <= '0;
			best_row_q <= '0;
		end else if (dist_valid && (!have_q || (dist_s3 < best_q))) begin
			have_q     <= 1'b1;
			best_q     <= dist_s3;
			best_col_q <= col_s3;
			best_row_q <= row_s3;
		end
	end

	// result, shown for the one cycle spent in the done state
	assign done          = (state_q == ST_DONE);
	assign found         = have_q;
	assign match_col     = COL_W'(best_col_q);
	assign match_row     = ROW_W'(best_row_q);
	assign best_distance = best_q;

	`RMNS_ASSERT_NEXT(a_done_one_cycle, clk, arst_n, done, !done)
	`RMNS_ASSERT(a_idle_pipe_empty, clk, arst_n, busy || !pipe_busy)
	`RMNS_ASSERT(a_dist_in_scan, clk, arst_n, !dist_valid || state_q == ST_SCAN || state_q == ST_DRAIN)
	`RMNS_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && cmd == CMD_QUERY, busy)

endmodule

/* dv/rmns_match_checker.sv */
// Checker for the rectify map nearest search block: mirrors both maps and the radius,
// predicts one match per accepted query and compares it with each result on done.
// Depends on rmns_pkg.
module rmns_match_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 window_radius_we,
	input  logic        [rmns_pkg::RADIUS_W-1:0] window_radius,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic        [rmns_pkg::CMD_W-1:0]    cmd,
	input  logic        [rmns_pkg::ROW_W-1:0]    row,
	input  logic        [rmns_pkg::COL_W-1:0]    col,
	input  logic signed [rmns_pkg::COORD_W-1:0]  map_x,
	input  logic signed [rmns_pkg::COORD_W-1:0]  map_y,
	input  logic                                 done,
	input  logic                                 found,
	input  logic        [rmns_pkg::COL_W-1:0]    match_col,
	input  logic        [rmns_pkg::ROW_W-1:0]    match_row,
	input  logic        [rmns_pkg::DIST_W-1:0]   best_distance,
	output int                                   pending,
	output int                                   failures
);
	import rmns_pkg::*;

	localparam int IMG_W     = IMG_WIDTH_DEF;
	localparam int IMG_H     = IMG_HEIGHT_DEF;
	localparam int MAP_DEPTH = IMG_W * IMG_H;

	typedef struct packed {
		logic              found;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [DIST_W-1:0] distance;
	} match_t;

	logic signed [COORD_W-1:0] ref_x_mem [MAP_DEPTH];
	logic signed [COORD_W-1:0] ref_y_mem [MAP_DEPTH];
	logic signed [COORD_W-1:0] qry_x_mem [MAP_DEPTH];
	logic signed [COORD_W-1:0] qry_y_mem [MAP_DEPTH];

	int     search_radius;
	int     mismatch_count;
	int     wr_addr;
	match_t expected_matches [$];
	match_t exp_m;

	// Scan the clamped window around the query point in raster order; strict less-than
	// keeps the first position on a tie.
	function automatic match_t nearest_match(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] pcol);
		match_t m;
		int     a, i, j, qx, qy, rx, ry, y0, y1, x0, x1;
		longint d, best;
		m = '0;
		best = 0;
		if (int'(prow) >= IMG_H || int'(pcol) >= IMG_W)
			return m;
		a = int'(prow) * IMG_W + int'(pcol);
		qx = qry_x_mem[a];
		qy = qry_y_mem[a];
		y0 = (qy - search_radius < 0) ? 0 : qy - search_radius;
		y1 = (qy + search_radius > IMG_H) ? IMG_H : qy + search_radius;
		x0 = (qx - search_radius < 0) ? 0 : qx - search_radius;
		x1 = (qx + search_radius > IMG_W) ? IMG_W : qx + search_radius;
		for (i = y0; i < y1; i++) begin
			for (j = x0; j < x1; j++) begin
				a = i * IMG_W + j;
				rx = ref_x_mem[a];
				ry = ref_y_mem[a];
				d = longint'(rx - qx) * (rx - qx) + longint'(ry - qy) * (ry - qy);
				if (d > DIST_MAX)
					d = DIST_MAX;
				if (!m.found || d < best) begin
					best = d;
					m.found = 1'b1;
					m.col = j[COL_W-1:0];
					m.row = i[ROW_W-1:0];
					m.distance = d[DIST_W-1:0];
				end
			end
		end
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_radius = int'(RADIUS_RESET);
			mismatch_count = 0;
			expected_matches.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (window_radius_we)
				search_radius = int'(window_radius);
			if (start && !busy) begin
				wr_addr = int'(row) * IMG_W + int'(col);
				case (cmd)
					CMD_LOAD_REF: begin
						if (int'(row) < IMG_H && int'(col) < IMG_W) begin
							ref_x_mem[wr_addr] = map_x;
							ref_y_mem[wr_addr] = map_y;
						end
					end
					CMD_LOAD_QRY: begin
						if (int'(row) < IMG_H && int'(col) < IMG_W) begin
							qry_x_mem[wr_addr] = map_x;
							qry_y_mem[wr_addr] = map_y;
						end
					end
					CMD_QUERY: expected_matches = {expected_matches, nearest_match(row, col)};
					default: ;
				endcase
			end
			if (done) begin
				if (expected_matches.size() == 0) begin
					$error("unexpected result: found %0d col %0d row %0d distance %0d",
						found, match_col, match_row, best_distance);
					mismatch_count++;
				end else begin
					exp_m = expected_matches.pop_front();
					if (found !== exp_m.found) begin
						$error("found: expected %0d, got %0d", exp_m.found, found);
						mismatch_count++;
					end
					if (match_col !== exp_m.col) begin
						$error("match_col: expected %0d, got %0d", exp_m.col, match_col);
						mismatch_count++;
					end
					if (match_row !== exp_m.row) begin
						$error("match_row: expected %0d, got %0d", exp_m.row, match_row);
						mismatch_count++;
					end
					if (best_distance !== exp_m.distance) begin
						$error("best_distance: expected %0d, got %0d", exp_m.distance,
							best_distance);
						mismatch_count++;
					end
				end
			end
			pending <= expected_matches.size();
			failures <= mismatch_count;
		end
	end

endmodule

/* dv/testbench.sv */
// Top of the rectify map nearest search testbench: clock, reset, item stimulus, verdict.
// Depends on rmns_pkg, rectify_map_nearest_search_top and rmns_match_checker.
module testbench;
	import rmns_pkg::*;

	localparam int IMG_W     = IMG_WIDTH_DEF;
	localparam int IMG_H     = IMG_HEIGHT_DEF;
	localparam int MAP_DEPTH = IMG_W * IMG_H;

	// The fourth command code has no meaning; the block must drop it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      window_radius_we;
	logic [RADIUS_W-1:0]       window_radius;
	logic                      start;
	logic                      busy;
	logic [CMD_W-1:0]          cmd;
	logic [ROW_W-1:0]          row;
	logic [COL_W-1:0]          col;
	logic signed [COORD_W-1:0] map_x;
	logic signed [COORD_W-1:0] map_y;
	logic                      done;
	logic                      found;
	logic [COL_W-1:0]          match_col;
	logic [ROW_W-1:0]          match_row;
	logic [DIST_W-1:0]         best_distance;
	int                        pending;
	int                        failures;

	// Stimulus-side bookkeeping: which reference entries hold a value, so that no query
	// window ever touches an entry that was never loaded.
	bit ref_loaded [MAP_DEPTH];
	int radius_now;
	int item_count;
	bit gaps_on;

	rectify_map_nearest_search_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_radius_we (window_radius_we),
		.window_radius    (window_radius),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.row              (row),
		.col              (col),
		.map_x            (map_x),
		.map_y            (map_y),
		.done             (done),
		.found            (found),
		.match_col        (match_col),
		.match_row        (match_row),
		.best_distance    (best_distance)
	);

	rmns_match_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.window_radius_we (window_radius_we),
		.window_radius    (window_radius),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.row              (row),
		.col              (col),
		.map_x            (map_x),
		.map_y            (map_y),
		.done             (done),
		.found            (found),
		.match_col        (match_col),
		.match_row        (match_row),
		.best_distance    (best_distance),
		.pending          (pending),
		.failures         (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: ends a run that hangs.
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int rand_coord();
		return int'($urandom_range(2047)) - 1024;
	endfunction

	// Pick a query coordinate for radius r whose clamped window along one axis is
	// small: clipped at the low edge, clipped at the high edge, or (for r of 1 or 2)
	// fully inside the image.
	function automatic void pick_span(input int r, input int lim, output int q,
			output int lo, output int hi);
		int k;
		k = int'($urandom_range(1, (2 * r < 4) ? 2 * r : 4));
		case ($urandom_range(2))
			0: q = k - r;
			1: q = lim - k + r;
			default: q = (2 * r <= 4) ? int'($urandom_range(r, lim - r)) : k - r;
		endcase
		lo = (q - r < 0) ? 0 : q - r;
		hi = (q + r > lim) ? lim : q + r;
	endfunction

	// Present one item at a falling edge, after a random idle gap when gaps_on is set, and
	// hold it until a rising edge sees busy low. start stays high into the next call, so
	// the next item can follow back to back.
	task automatic send_item(input logic [CMD_W-1:0] c, input int r, input int cl,
			input int x, input int y);
		bit in_img;
		in_img = (r < IMG_H) && (cl < IMG_W);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		row   <= r[ROW_W-1:0];
		col   <= cl[COL_W-1:0];
		map_x <= x[COORD_W-1:0];
		map_y <= y[COORD_W-1:0];
		do @(posedge clk); while (busy !== 1'b0);
		if (c == CMD_LOAD_REF && in_img)
			ref_loaded[r * IMG_W + cl] = 1'b1;
		// dropped items (unused code, loads off the image) do not count
		if (c == CMD_QUERY || (c != CMD_UNUSED && in_img))
			item_count++;
	endtask

	// Items off the happy path: the unused code, loads off the image (dropped) and
	// queries off the image (answered with an all-zero result).
	task automatic send_noise();
		int r, cl;
		if ($urandom_range(1)) begin
			r = int'($urandom_range(IMG_H, 255));
			cl = int'($urandom_range(511));
		end else begin
			r = int'($urandom_range(255));
			cl = int'($urandom_range(IMG_W, 511));
		end
		case ($urandom_range(3))
			0: send_item(CMD_UNUSED, int'($urandom_range(255)), int'($urandom_range(511)),
				rand_coord(), rand_coord());
			1: send_item(CMD_LOAD_REF, r, cl, rand_coord(), rand_coord());
			2: send_item(CMD_LOAD_QRY, r, cl, rand_coord(), rand_coord());
			default: send_item(CMD_QUERY, r, cl, rand_coord(), rand_coord());
		endcase
	endtask

	// Write the radius with the block idle: drop start, wait for every outstanding
	// result, give a load in flight time to land, then pulse the write enable.
	task automatic write_radius(input int v);
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		window_radius_we <= 1'b1;
		window_radius    <= v[RADIUS_W-1:0];
		@(negedge clk);
		window_radius_we <= 1'b0;
		radius_now = v;
	endtask

	// One search: load a query entry, make sure every reference entry in its window
	// holds a value (reloading some at random), then issue the query. Reference points
	// cluster near the target so that equal distances and ties come up often.
	task automatic search_case();
		int qrow, qcol, qx, qy, x0, x1, y0, y1, i, j, rx, ry;
		qrow = int'($urandom_range(IMG_H - 1));
		qcol = int'($urandom_range(IMG_W - 1));
		if (radius_now == 0 || $urandom_range(9) == 0) begin
			// target far off the image: the window comes out empty
			qx = $urandom_range(1) ? -1024 : int'($urandom_range(IMG_W + radius_now, 1023));
			qy = rand_coord();
			x0 = 0;
			x1 = 0;
			y0 = 0;
			y1 = 0;
		end else begin
			pick_span(radius_now, IMG_W, qx, x0, x1);
			pick_span(radius_now, IMG_H, qy, y0, y1);
		end
		send_item(CMD_LOAD_QRY, qrow, qcol, qx, qy);
		for (i = y0; i < y1; i++) begin
			for (j = x0; j < x1; j++) begin
				if (!ref_loaded[i * IMG_W + j] || $urandom_range(3) == 0) begin
					if ($urandom_range(3) == 0) begin
						rx = rand_coord();
						ry = rand_coord();
					end else begin
						rx = qx + int'($urandom_range(4)) - 2;
						ry = qy + int'($urandom_range(4)) - 2;
					end
					send_item(CMD_LOAD_REF, i, j, rx, ry);
				end
				if ($urandom_range(15) == 0)
					send_noise();
			end
		end
		if ($urandom_range(4) == 0)
			send_noise();
		// map fields are don't-care on a query: drive garbage
		send_item(CMD_QUERY, qrow, qcol, rand_coord(), rand_coord());
	endtask

	initial begin
		int first_count, ph, v;
		arst_n           = 1'b0;
		window_radius_we = 1'b0;
		window_radius    = '0;
		start            = 1'b0;
		cmd              = CMD_LOAD_REF;
		row              = '0;
		col              = '0;
		map_x            = '0;
		map_y            = '0;
		radius_now       = int'(RADIUS_RESET);
		item_count       = 0;
		gaps_on          = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed items, first at the reset radius, then at radii 0 and 63. Corner targets
		// are pulled outside the image so each window clamps down to one or two positions.
		send_item(CMD_LOAD_QRY, 0, 0, -29, -29);
		send_item(CMD_LOAD_REF, 0, 0, -1024, -1024);
		send_item(CMD_QUERY, 0, 0, 1023, -1024);
		send_item(CMD_LOAD_QRY, IMG_H - 1, IMG_W - 1, IMG_W - 1 + 30, IMG_H - 1 + 30);
		send_item(CMD_LOAD_REF, IMG_H - 1, IMG_W - 1, 1023, 1023);
		send_item(CMD_QUERY, IMG_H - 1, IMG_W - 1, -1024, 1023);
		// tie on the top row: the leftmost position must win
		send_item(CMD_LOAD_QRY, 5, 7, -28, -29);
		send_item(CMD_LOAD_REF, 0, 1, -1024, -1024);
		send_item(CMD_QUERY, 5, 7, 0, 0);
		// dropped items, then queries off the image
		send_item(CMD_LOAD_REF, 255, 511, 1023, 1023);
		send_item(CMD_LOAD_QRY, 0, IMG_W, 0, 0);
		send_item(CMD_UNUSED, 255, 511, -1, -1);
		send_item(CMD_QUERY, IMG_H, 0, 0, 0);
		send_item(CMD_QUERY, 0, IMG_W, 0, 0);
		send_item(CMD_QUERY, 255, 511, -1, -1);
		// target past the right edge: empty window
		send_item(CMD_LOAD_QRY, 1, 1, 1023, 1023);
		send_item(CMD_QUERY, 1, 1, 0, 0);
		// radius zero always gives an empty window
		write_radius(0);
		send_item(CMD_QUERY, 0, 0, 0, 0);
		// widest radius, window clamped to the origin
		write_radius(63);
		send_item(CMD_LOAD_QRY, 2, 2, -62, -62);
		send_item(CMD_QUERY, 2, 2, 0, 0);

		// Random phases, each at its own radius. Phase 1 runs with no idle gaps.
		first_count = item_count;
		ph = 0;
		while (item_count - first_count < 120) begin
			case (ph % 5)
				0: v = 2;
				1: v = 1;
				2: v = 63;
				3: v = int'($urandom_range(3, 62));
				default: v = int'($urandom_range(63));
			endcase
			write_radius(v);
			gaps_on = (ph != 1);
			repeat ($urandom_range(4, 8)) search_case();
			ph++;
		end

		// Drain: drop start, wait for every result, then idle before the verdict.
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/rmns_pkg.sv
sv/rmns_dist.sv
sv/rectify_map_nearest_search_top.sv
dv/rmns_match_checker.sv
dv/testbench.sv
